// File: hdl/ras_pkg.sv
// Shared constants and types for the region adjacency scanner.
// No dependencies; imported by region_adjacency_scanner_core.
package ras_pkg;

  // Capacity of the label space, the scan line and the frame height
  localparam int MAX_REGIONS  = 256;
  localparam int MAX_WIDTH    = 1024;
  localparam int HEIGHT_LIMIT = 1024;

  // Field and register widths
  localparam int LABEL_W    = 9;
  localparam int REG_W      = $clog2(MAX_REGIONS);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(HEIGHT_LIMIT);
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 11;
  localparam int COUNT_W    = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 2'd2;

  // Stored column label meaning "no region"
  localparam logic [LABEL_W-1:0] NO_REGION = {LABEL_W{1'b1}};

  // Result queue geometry
  localparam int EQ_DEPTH = 8;
  localparam int EQ_PTR_W = $clog2(EQ_DEPTH);
  localparam int EQ_CNT_W = EQ_PTR_W + 1;

  // One emitted adjacency pair
  typedef struct packed {
    logic [REG_W-1:0] lo;
    logic [REG_W-1:0] hi;
    logic             last;
  } pair_t;

endpackage

// File: hdl/ras_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read returns the old contents when the same entry is written in that cycle.
module ras_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/region_adjacency_scanner_core.sv
// Region adjacency scanner top level: scan position, neighbour lookup,
// adjacency matrix read-modify-write and result queue. Uses ras_pkg, ras_ram.
//
//  channel  direction  beat                       handshake
//  cfg      in         cfg_index, cfg_data        cfg_valid / cfg_ready
//  in       in         label                      in_valid / in_ready
//  out      out        region_low, region_high,   out_valid / out_ready
//                      last_of_run
//
// No pixel is taken while the previous one is in its first stage: the
// adjacency RAM has one read and one write port, and each pixel needs two
// read-modify-writes of it (left, upper). Results pass the first and second
// stage registers and wait in an 8-entry queue, and input also stalls when
// fewer than four entries are free (the pixel in its second stage and the
// one being taken may add two each). Reset needs no clearing pass: matrix
// rows carry valid bits and column labels are qualified by the widest row
// seen in the frame. Config beats are always taken (cfg_ready is tied high).
module region_adjacency_scanner_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ras_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ras_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [ras_pkg::LABEL_W-1:0] label,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ras_pkg::REG_W-1:0]       region_low,
  output logic [ras_pkg::REG_W-1:0]       region_high,
  output logic                            last_of_run
);
  import ras_pkg::*;

  // Configuration registers
  logic [WIDTH_W-1:0]  frame_width;
  logic [HEIGHT_W-1:0] frame_height;
  logic [COUNT_W-1:0]  label_limit;
  logic [WIDTH_W-1:0]  width_eff;
  logic [HEIGHT_W-1:0] height_eff;
  logic [COUNT_W-1:0]  count_eff;

  // Scan state
  logic [COL_W-1:0]   col_pos;
  logic [ROW_W-1:0]   row_pos;
  logic               left_live;
  logic [REG_W-1:0]   left_lab;
  logic [WIDTH_W-1:0] hi_water;

  // Accept-side decode
  logic               accept;
  logic [REG_W-1:0]   lab8;
  logic               kept;
  logic [WIDTH_W-1:0] col_next_w;
  logic               row_end;
  logic               frame_end;
  logic               col_live;
  logic               left_ok;
  logic [REG_W-1:0]   left_lo;
  logic [REG_W-1:0]   left_hi;

  // First stage (column label and left row return)
  logic             s1_valid;
  logic             s1_kept;
  logic [REG_W-1:0] s1_lab;
  logic [COL_W-1:0] s1_col;
  logic             s1_col_live;
  logic             s1_left_ok;
  logic [REG_W-1:0] s1_left_lo;
  logic [REG_W-1:0] s1_left_hi;
  logic             s1_frame_end;

  // Second stage (upper row return)
  logic             s2_valid;
  logic             s2_left_new;
  logic [REG_W-1:0] s2_left_lo;
  logic [REG_W-1:0] s2_left_hi;
  logic             s2_up_ok;
  logic [REG_W-1:0] s2_up_lo;
  logic [REG_W-1:0] s2_up_hi;
  logic             s2_frame_end;

  // Column label memory
  logic [LABEL_W-1:0] col_rdata;
  logic [LABEL_W-1:0] col_wdata;
  logic [LABEL_W-1:0] up_eff;
  logic               up_ok;
  logic [REG_W-1:0]   up_lo;
  logic [REG_W-1:0]   up_hi;

  // Adjacency matrix memory, one row per smaller label
  logic                   adj_we;
  logic [REG_W-1:0]       adj_waddr;
  logic [MAX_REGIONS-1:0] adj_wdata;
  logic [REG_W-1:0]       adj_raddr;
  logic [REG_W-1:0]       adj_raddr_q;
  logic [MAX_REGIONS-1:0] adj_rdata;
  logic [MAX_REGIONS-1:0] row_eff;
  logic [MAX_REGIONS-1:0] row_valid;
  logic [REG_W-1:0]       mark_bit;
  logic                   fwd_hit;
  logic [MAX_REGIONS-1:0] fwd_data;
  logic                   left_new;
  logic                   up_new;
  logic                   clear_now;

  // Result queue
  pair_t                eq_mem [EQ_DEPTH];
  logic [EQ_PTR_W-1:0]  eq_wr;
  logic [EQ_PTR_W-1:0]  eq_rd;
  logic [EQ_CNT_W-1:0]  eq_cnt;
  logic [1:0]           push_cnt;
  logic                 pop;
  pair_t                push_first;
  pair_t                push_second;
  pair_t                eq_head;

  // Configuration write port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_W'(MAX_WIDTH);
      frame_height <= HEIGHT_W'(HEIGHT_LIMIT);
      label_limit  <= COUNT_W'(MAX_REGIONS);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[WIDTH_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[HEIGHT_W-1:0];
        CFG_REGION_COUNT: label_limit  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp configuration to the supported ranges
  always_comb begin
    if (frame_width == '0) begin
      width_eff = WIDTH_W'(1);
    end else if (frame_width > WIDTH_W'(MAX_WIDTH)) begin
      width_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      width_eff = frame_width;
    end
    if (frame_height == '0) begin
      height_eff = HEIGHT_W'(1);
    end else if (frame_height > HEIGHT_W'(HEIGHT_LIMIT)) begin
      height_eff = HEIGHT_W'(HEIGHT_LIMIT);
    end else begin
      height_eff = frame_height;
    end
    count_eff = (label_limit > COUNT_W'(MAX_REGIONS)) ? COUNT_W'(MAX_REGIONS)
                                                       : label_limit;
  end

  // Decode the incoming pixel
  assign in_ready   = !s1_valid && (eq_cnt <= EQ_CNT_W'(EQ_DEPTH - 4));
  assign accept     = in_valid && in_ready;
  assign lab8       = label[REG_W-1:0];
  assign kept       = !label[LABEL_W-1] && (COUNT_W'(lab8) < count_eff);
  assign col_next_w = WIDTH_W'(col_pos) + WIDTH_W'(1);
  assign row_end    = col_next_w >= width_eff;
  assign frame_end  = row_end && ((HEIGHT_W'(row_pos) + HEIGHT_W'(1)) >= height_eff);
  assign col_live   = WIDTH_W'(col_pos) < hi_water;
  assign left_ok    = kept && left_live && (left_lab != lab8);
  assign left_lo    = (lab8 < left_lab) ? lab8 : left_lab;
  assign left_hi    = (lab8 < left_lab) ? left_lab : lab8;

  // Advance the scan position; track the widest row of the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos   <= '0;
      row_pos   <= '0;
      left_live <= 1'b0;
      hi_water  <= '0;
    end else if (accept) begin
      if (kept) begin
        left_live <= 1'b1;
      end
      if (row_end) begin
        col_pos   <= '0;
        left_live <= 1'b0;
        if (frame_end) begin
          row_pos  <= '0;
          hi_water <= '0;
        end else begin
          row_pos  <= row_pos + ROW_W'(1);
          hi_water <= (col_next_w > hi_water) ? col_next_w : hi_water;
        end
      end else begin
        col_pos <= col_pos + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && kept) begin
      left_lab <= lab8;
    end
  end

  // First stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_kept      <= kept;
    s1_lab       <= lab8;
    s1_col       <= col_pos;
    s1_col_live  <= col_live;
    s1_left_ok   <= left_ok;
    s1_left_lo   <= left_lo;
    s1_left_hi   <= left_hi;
    s1_frame_end <= frame_end;
  end

  // Column labels: read at the beat, write back the effective label
  ras_ram #(
    .WIDTH(LABEL_W),
    .DEPTH(MAX_WIDTH)
  ) u_col_ram (
    .clk  (clk),
    .we   (s1_valid),
    .waddr(s1_col),
    .wdata(col_wdata),
    .raddr(col_pos),
    .rdata(col_rdata)
  );

  assign up_eff    = s1_col_live ? col_rdata : NO_REGION;
  assign col_wdata = s1_kept ? {1'b0, s1_lab} : up_eff;
  assign up_ok     = s1_kept && !up_eff[LABEL_W-1] && (up_eff[REG_W-1:0] != s1_lab);
  assign up_lo     = (s1_lab < up_eff[REG_W-1:0]) ? s1_lab : up_eff[REG_W-1:0];
  assign up_hi     = (s1_lab < up_eff[REG_W-1:0]) ? up_eff[REG_W-1:0] : s1_lab;

  // Adjacency row as of now: forward last cycle's write, mask stale rows
  always_comb begin
    if (fwd_hit) begin
      row_eff = fwd_data;
    end else if (row_valid[adj_raddr_q]) begin
      row_eff = adj_rdata;
    end else begin
      row_eff = '0;
    end
  end

  assign left_new  = s1_valid && s1_left_ok && !row_eff[s1_left_hi];
  assign up_new    = s2_valid && s2_up_ok && !row_eff[s2_up_hi];
  assign clear_now = s2_valid && s2_frame_end;

  // Share the single RAM ports: left pair in stage one, upper pair in stage two
  assign adj_raddr = s1_valid ? up_lo : left_lo;
  assign adj_we    = left_new || up_new;
  assign adj_waddr = s2_valid ? s2_up_lo : s1_left_lo;
  assign mark_bit  = s2_valid ? s2_up_hi : s1_left_hi;
  assign adj_wdata = row_eff | (MAX_REGIONS'(1) << mark_bit);

  ras_ram #(
    .WIDTH(MAX_REGIONS),
    .DEPTH(MAX_REGIONS)
  ) u_adj_ram (
    .clk  (clk),
    .we   (adj_we),
    .waddr(adj_waddr),
    .wdata(adj_wdata),
    .raddr(adj_raddr),
    .rdata(adj_rdata)
  );

  // Hold read address and forwarding data; the forwarding flag and row valid bits drop at frame end
  always_ff @(posedge clk) begin
    adj_raddr_q <= adj_raddr;
    fwd_data    <= adj_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst || clear_now) begin
      fwd_hit   <= 1'b0;
      row_valid <= '0;
    end else begin
      fwd_hit <= adj_we && (adj_waddr == adj_raddr);
      if (adj_we) begin
        row_valid[adj_waddr] <= 1'b1;
      end
    end
  end

  // Second stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_left_new  <= left_new;
    s2_left_lo   <= s1_left_lo;
    s2_left_hi   <= s1_left_hi;
    s2_up_ok     <= up_ok;
    s2_up_lo     <= up_lo;
    s2_up_hi     <= up_hi;
    s2_frame_end <= s1_frame_end;
  end

  // Queue up to two results per pixel, left pair first
  always_comb begin
    push_first  = '{lo: s2_left_lo, hi: s2_left_hi, last: !up_new};
    push_second = '{lo: s2_up_lo, hi: s2_up_hi, last: 1'b1};
    push_cnt    = 2'd0;
    if (s2_valid) begin
      unique case ({s2_left_new, up_new})
        2'b11: push_cnt = 2'd2;
        2'b10: push_cnt = 2'd1;
        2'b01: begin
          push_cnt   = 2'd1;
          push_first = push_second;
        end
        default: push_cnt = 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      eq_mem[eq_wr] <= push_first;
    end
    if (push_cnt == 2'd2) begin
      eq_mem[eq_wr + EQ_PTR_W'(1)] <= push_second;
    end
  end

  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      eq_wr  <= '0;
      eq_rd  <= '0;
      eq_cnt <= '0;
    end else begin
      eq_wr  <= eq_wr + EQ_PTR_W'(push_cnt);
      eq_rd  <= eq_rd + EQ_PTR_W'(pop);
      eq_cnt <= eq_cnt + EQ_CNT_W'(push_cnt) - EQ_CNT_W'(pop);
    end
  end

  // Present the queue head
  assign eq_head     = eq_mem[eq_rd];
  assign out_valid   = eq_cnt != '0;
  assign region_low  = eq_head.lo;
  assign region_high = eq_head.hi;
  assign last_of_run = eq_head.last;

endmodule
